// File: rtl/quad_pick_drag_point_in_polygon_unit_defines.svh
// Assertion macros for the quad pick and drag unit.
`ifndef QUAD_PICK_DRAG_POINT_IN_POLYGON_UNIT_DEFINES_SVH
`define QUAD_PICK_DRAG_POINT_IN_POLYGON_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define QPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every edge, reset included.
`define QPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define QPD_ASSERT(lbl, prop, msg)
`define QPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/qpd_pkg.sv
`timescale 1ns / 1ps
package qpd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_CORNERS    = 4;
    localparam int PIX_BITS       = 13;
    localparam int SIZE_BITS      = 12;
    localparam int TOL_BITS       = 14;
    // dividend: |2*pix - size| << 15 plus size
    localparam int DIV_BITS       = 29;

    localparam logic [SIZE_BITS-1:0] WIDTH_RST  = 12'd800;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RST = 12'd600;
    localparam logic [TOL_BITS-1:0]  TOL_RST    = 14'd819;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_TOL    = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_PRESS   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_MOTION  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GRAB,
        B_EDGE_MUL,
        B_EDGE_CMP,
        B_TRANS,
        B_EMIT
    } back_state_t;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic empty;
    } q_ctl_t;

    function automatic logic signed [31:0] corner_rst_x(input int idx);
        logic signed [31:0] v;
        v = (idx == 0 || idx == 3) ? -32'sd8192 : 32'sd8192;
        return v;
    endfunction

    function automatic logic signed [31:0] corner_rst_y(input int idx);
        logic signed [31:0] v;
        v = (idx == 0 || idx == 1) ? 32'sd8192 : -32'sd8192;
        return v;
    endfunction

endpackage

// File: rtl/qpd_front.sv
`timescale 1ns / 1ps
module qpd_front import qpd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,
    input  logic [1:0]                s_tuser,
    input  logic [SIZE_BITS-1:0]      win_w,
    input  logic [SIZE_BITS-1:0]      win_h,
    output logic                      push,
    input  logic                      full,
    output logic [2+2*COORD_BITS-1:0] push_data
);

    localparam logic signed [33:0] CMAX = (34'sd1 <<< (COORD_BITS - 1)) - 34'sd1;
    localparam logic signed [33:0] CMIN = -(34'sd1 <<< (COORD_BITS - 1));

    front_state_t state_reg, state_next;
    logic                  axis_reg;
    logic [4:0]            cnt_reg;
    logic [DIV_BITS-1:0]   dvd_reg;
    logic [12:0]           dsr_reg;
    logic [12:0]           rem_reg;
    logic                  neg_reg;
    logic [1:0]            cmd_reg;
    logic [PIX_BITS-1:0]   py_reg;
    logic [COORD_BITS-1:0] nx_reg, ny_reg;

    logic [SIZE_BITS-1:0]  sx, sy;
    logic signed [14:0]    numx, numy;
    logic [13:0]           magx, magy;
    logic [13:0]           t;
    logic                  ge;
    logic [12:0]           rem_n;
    logic [DIV_BITS-1:0]   dvd_n;
    logic signed [33:0]    v;
    logic [COORD_BITS-1:0] sat;
    logic                  last_step;

    assign sx = (win_w < 12'd2) ? 12'd2 : win_w;
    assign sy = (win_h < 12'd2) ? 12'd2 : win_h;
    // x: 2*px - W ; y flipped: H - 2*py
    assign numx = {{2{s_tdata[12]}}, s_tdata[12:0]} * 15'sd2 - $signed({3'b0, sx});
    assign numy = $signed({3'b0, sy}) - {{2{py_reg[12]}}, py_reg} * 15'sd2;
    assign magx = numx[14] ? 14'(-numx) : numx[13:0];
    assign magy = numy[14] ? 14'(-numy) : numy[13:0];

    // restoring divider, one quotient bit per cycle
    assign t     = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign ge    = t >= {1'b0, dsr_reg};
    assign rem_n = ge ? 13'(t - {1'b0, dsr_reg}) : t[12:0];
    assign dvd_n = {dvd_reg[DIV_BITS-2:0], ge};
    assign last_step = cnt_reg == 5'(DIV_BITS - 1);

    always_comb begin
        v = $signed({5'b0, dvd_n});
        if (neg_reg) v = -v;
        if (v > CMAX)      sat = CMAX[COORD_BITS-1:0];
        else if (v < CMIN) sat = CMIN[COORD_BITS-1:0];
        else               sat = v[COORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= F_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) state_next = F_DIV;
            end
            F_DIV: begin
                if (last_step && axis_reg) state_next = F_PUSH;
            end
            F_PUSH: begin
                push = !full;
                if (!full) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_tvalid) begin
            cmd_reg  <= s_tuser;
            py_reg   <= s_tdata[25:13];
            axis_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= {sx, 1'b0};
            dvd_reg  <= {magx, 3'b000, sx};
            neg_reg  <= numx[14];
        end else if (state_reg == F_DIV) begin
            if (last_step) begin
                cnt_reg  <= '0;
                rem_reg  <= '0;
                if (!axis_reg) begin
                    nx_reg   <= sat;
                    axis_reg <= 1'b1;
                    dsr_reg  <= {sy, 1'b0};
                    dvd_reg  <= {magy, 3'b000, sy};
                    neg_reg  <= numy[14];
                end else begin
                    ny_reg <= sat;
                end
            end else begin
                cnt_reg <= cnt_reg + 5'd1;
                rem_reg <= rem_n;
                dvd_reg <= dvd_n;
            end
        end
    end

    assign push_data = {ny_reg, nx_reg, cmd_reg};

endmodule

// File: rtl/qpd_queue.sv
`timescale 1ns / 1ps
module qpd_queue import qpd_pkg::*; #(
    parameter int WIDTH = 2 + 2 * COORD_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  q_ctl_t           ctl_in,
    output q_ctl_t           ctl_out,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             do_push, do_pop;

    assign do_push = ctl_in.push && cnt_reg != 2'd2;
    assign do_pop  = ctl_in.pop && cnt_reg != 2'd0;

    always_comb begin
        ctl_out       = ctl_in;
        ctl_out.full  = cnt_reg == 2'd2;
        ctl_out.empty = cnt_reg == 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_push) wp_reg <= !wp_reg;
            if (do_pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rp_reg];

endmodule

// File: rtl/qpd_back.sv
`timescale 1ns / 1ps
module qpd_back import qpd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_empty,
    output logic                      pop,
    input  logic [2+2*COORD_BITS-1:0] q_data,
    input  logic [TOL_BITS-1:0]       tol,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [8*COORD_BITS+3:0]   out_bits
);

    localparam int C = COORD_BITS;
    localparam logic signed [C+1:0] SMAX = (C+2)'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [C+1:0] SMIN = (C+2)'(-(64'sd1 <<< (C - 1)));

    back_state_t state_reg, state_next;

    // corners rotate during serial passes so index 0 and 1 are the only taps
    logic signed [C-1:0] cx_reg [NUM_CORNERS];
    logic signed [C-1:0] cy_reg [NUM_CORNERS];
    logic                drag_reg, held_reg;
    logic [1:0]          hidx_reg;
    logic signed [C-1:0] lx_reg, ly_reg;
    logic signed [C-1:0] nx_reg, ny_reg;
    logic [1:0]          cnt_reg;
    logic                found_reg;
    logic [1:0]          fidx_reg;
    logic                cross_reg;
    logic                cond_reg, dypos_reg;
    logic signed [2*C+1:0] lhs_reg, rhs_reg;
    logic                out_v_reg;
    logic [8*C+3:0]      out_reg;

    logic signed [C+1:0] dx, dy_g, ax, ay;
    logic                match;
    logic signed [C:0]   ea, edy, eb, ec;
    logic                cond, left;
    logic signed [C+1:0] tx, ty;
    logic signed [C-1:0] sx, sy;
    logic                out_free;
    logic [8*C+3:0]      pack;

    assign out_free = !out_v_reg || m_tready;

    // grab test on corner 0
    assign dx    = (C+2)'(nx_reg) - (C+2)'(cx_reg[0]);
    assign dy_g  = (C+2)'(ny_reg) - (C+2)'(cy_reg[0]);
    assign ax    = dx[C+1] ? -dx : dx;
    assign ay    = dy_g[C+1] ? -dy_g : dy_g;
    assign match = ax < $signed({{(C+2-TOL_BITS){1'b0}}, tol})
                && ay < $signed({{(C+2-TOL_BITS){1'b0}}, tol});

    // edge from corner 0 to corner 1
    assign cond = (ny_reg < cy_reg[0]) != (ny_reg < cy_reg[1]);
    assign edy  = (C+1)'(cy_reg[1]) - (C+1)'(cy_reg[0]);
    assign ea   = (C+1)'(nx_reg) - (C+1)'(cx_reg[1]);
    assign eb   = (C+1)'(ny_reg) - (C+1)'(cy_reg[1]);
    assign ec   = (C+1)'(cx_reg[1]) - (C+1)'(cx_reg[0]);
    assign left = dypos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);

    // translation of corner 0
    assign tx = (C+2)'(cx_reg[0]) + (C+2)'(nx_reg) - (C+2)'(lx_reg);
    assign ty = (C+2)'(cy_reg[0]) + (C+2)'(ny_reg) - (C+2)'(ly_reg);
    assign sx = (tx > SMAX) ? SMAX[C-1:0] : (tx < SMIN) ? SMIN[C-1:0] : tx[C-1:0];
    assign sy = (ty > SMAX) ? SMAX[C-1:0] : (ty < SMIN) ? SMIN[C-1:0] : ty[C-1:0];

    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            pack[2*k*C +: C]     = cx_reg[k];
            pack[(2*k+1)*C +: C] = cy_reg[k];
        end
        pack[8*C]       = drag_reg;
        pack[8*C+1]     = held_reg;
        pack[8*C+3:8*C+2] = held_reg ? hidx_reg : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= B_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    pop = 1'b1;
                    unique case (q_data[1:0])
                        CMD_PRESS:  state_next = B_GRAB;
                        CMD_MOTION: state_next = (drag_reg && !held_reg) ? B_TRANS : B_EMIT;
                        default:    state_next = B_EMIT;
                    endcase
                end
            end
            B_GRAB: begin
                if (cnt_reg == 2'd3)
                    state_next = (found_reg || match || held_reg) ? B_EMIT : B_EDGE_MUL;
            end
            B_EDGE_MUL: state_next = B_EDGE_CMP;
            B_EDGE_CMP: state_next = (cnt_reg == 2'd3) ? B_EMIT : B_EDGE_MUL;
            B_TRANS:    if (cnt_reg == 2'd3) state_next = B_EMIT;
            B_EMIT:     if (out_free) state_next = B_IDLE;
            default:    state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
                cx_reg[k] <= C'(corner_rst_x(k));
                cy_reg[k] <= C'(corner_rst_y(k));
            end
            drag_reg  <= 1'b0;
            held_reg  <= 1'b0;
            hidx_reg  <= 2'd0;
            out_v_reg <= 1'b0;
        end else begin
            if (m_tready && !(state_reg == B_EMIT && out_free)) out_v_reg <= 1'b0;
            case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        nx_reg    <= q_data[C+1:2];
                        ny_reg    <= q_data[2*C+1:C+2];
                        cnt_reg   <= 2'd0;
                        found_reg <= 1'b0;
                        cross_reg <= 1'b0;
                        case (q_data[1:0])
                            CMD_PRESS: begin
                                drag_reg <= 1'b1;
                                lx_reg   <= q_data[C+1:2];
                                ly_reg   <= q_data[2*C+1:C+2];
                            end
                            CMD_RELEASE: begin
                                drag_reg <= 1'b0;
                                held_reg <= 1'b0;
                            end
                            CMD_MOTION: begin
                                if (drag_reg && held_reg) begin
                                    cx_reg[hidx_reg] <= q_data[C+1:2];
                                    cy_reg[hidx_reg] <= q_data[2*C+1:C+2];
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                B_GRAB: begin
                    for (int k = 0; k < NUM_CORNERS; k++) begin
                        cx_reg[k] <= cx_reg[(k + 1) % NUM_CORNERS];
                        cy_reg[k] <= cy_reg[(k + 1) % NUM_CORNERS];
                    end
                    if (match && !found_reg) begin
                        found_reg <= 1'b1;
                        fidx_reg  <= cnt_reg;
                    end
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        if (found_reg) begin
                            held_reg <= 1'b1;
                            hidx_reg <= fidx_reg;
                        end else if (match) begin
                            held_reg <= 1'b1;
                            hidx_reg <= cnt_reg;
                        end
                    end
                end
                B_EDGE_MUL: begin
                    cond_reg  <= cond;
                    dypos_reg <= edy > 0;
                    lhs_reg   <= ea * edy;
                    rhs_reg   <= eb * ec;
                end
                B_EDGE_CMP: begin
                    for (int k = 0; k < NUM_CORNERS; k++) begin
                        cx_reg[k] <= cx_reg[(k + 1) % NUM_CORNERS];
                        cy_reg[k] <= cy_reg[(k + 1) % NUM_CORNERS];
                    end
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) drag_reg <= cross_reg ^ (cond_reg && left);
                    else                 cross_reg <= cross_reg ^ (cond_reg && left);
                end
                B_TRANS: begin
                    for (int k = 0; k < NUM_CORNERS - 1; k++) begin
                        cx_reg[k] <= cx_reg[k + 1];
                        cy_reg[k] <= cy_reg[k + 1];
                    end
                    cx_reg[NUM_CORNERS-1] <= sx;
                    cy_reg[NUM_CORNERS-1] <= sy;
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        lx_reg <= nx_reg;
                        ly_reg <= ny_reg;
                    end
                end
                B_EMIT: begin
                    if (out_free) out_v_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_EMIT && out_free) out_reg <= pack;
    end

    assign m_tvalid = out_v_reg;
    assign out_bits = out_reg;

endmodule

// File: rtl/quad_pick_drag_point_in_polygon_unit.sv
`timescale 1ns / 1ps
// Quad pick and drag unit. Each pointer event (s_tuser = command: press,
// release, motion; s_tdata = pixel x and y) yields exactly one result on the
// m_ side: the four corners in Q2.14 plus dragging, vertex_grabbed and
// grabbed_index. The front stage maps the pixel position to normalized
// coordinates with a restoring divider, one quotient bit per cycle, x then y.
// A two-entry queue feeds the back stage, which runs the corner search on a
// press and then, if no corner matches and none is held, the crossing-number
// test (one edge multiply and one compare per edge), or the translation on a
// motion that drags the whole quad, then loads the output register. The front
// takes a new event only once it has pushed the last one into the queue; while
// the output is not held off, the divider sets the sustained rate.
// Window size and hit tolerance come from the cfg port (index 0 width,
// 1 height, 2 tolerance); the user must see that they are written only while
// the unit is idle, which the block itself leaves unenforced.
`include "quad_pick_drag_point_in_polygon_unit_defines.svh"
module quad_pick_drag_point_in_polygon_unit import qpd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [12:0] pixel_x, [25:13] pixel_y, rest zero
    input  logic [31:0]           s_tdata,
    // [1:0] command
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // corner0_x, corner0_y, ... corner3_y (COORD_BITS each), dragging,
    // vertex_grabbed, grabbed_index[1:0], zero pad
    output logic [((8*COORD_BITS+4+7)/8)*8-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [TOL_BITS-1:0]   cfg_data
);

    localparam int QW = 2 + 2 * COORD_BITS;
    localparam int OW = 8 * COORD_BITS + 4;
    localparam int MW = ((OW + 7) / 8) * 8;

    logic [SIZE_BITS-1:0] win_w_reg, win_h_reg;
    logic [TOL_BITS-1:0]  tol_reg;
    q_ctl_t               q_in, q_out;
    logic [QW-1:0]        wr_data, rd_data;
    logic [OW-1:0]        out_bits;
    logic                 push, pop;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_w_reg <= WIDTH_RST;
            win_h_reg <= HEIGHT_RST;
            tol_reg   <= TOL_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WIDTH:  win_w_reg <= cfg_data[SIZE_BITS-1:0];
                REG_HEIGHT: win_h_reg <= cfg_data[SIZE_BITS-1:0];
                REG_TOL:    tol_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and normalize
    qpd_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .win_w     (win_w_reg),
        .win_h     (win_h_reg),
        .push      (push),
        .full      (q_out.full),
        .push_data (wr_data)
    );

    always_comb begin
        q_in       = '0;
        q_in.push  = push;
        q_in.pop   = pop;
    end

    qpd_queue #(.WIDTH(QW)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (q_in),
        .ctl_out (q_out),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // back: pick, inside test, drag, result register
    qpd_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_out.empty),
        .pop      (pop),
        .q_data   (rd_data),
        .tol      (tol_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_bits (out_bits)
    );

    assign m_tdata = MW'(out_bits);

    // queue never written while full, never read while empty
    `QPD_ASSERT(a_q_no_overflow, q_out.push |-> !q_out.full, "queue overflow")
    `QPD_ASSERT(a_q_no_underflow, q_out.pop |-> !q_out.empty, "queue underflow")
    // a held corner implies an active drag in every result
    `QPD_ASSERT(a_grab_implies_drag, m_tvalid && out_bits[OW-3] |-> out_bits[OW-4], "grab w/o drag")
    // no result right after reset
    `QPD_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

// File: tb/sv/tb_quad_pick_drag_point_in_polygon_unit.sv
`timescale 1ns / 1ps
module tb_quad_pick_drag_point_in_polygon_unit;
    import qpd_pkg::*;

    localparam int CB = 16;
    localparam int MW = ((8*CB+4+7)/8)*8;
    // command code the block leaves without meaning: state stays, result still comes
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 19;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam int ITEMS_PER_PHASE = 240;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [31:0]    s_tdata;   // [12:0] pixel_x, [25:13] pixel_y, rest zero
    logic [1:0]     s_tuser;   // [1:0] command
    logic           m_tvalid;
    logic           m_tready;
    logic [MW-1:0]  m_tdata;   // corner0_x..corner3_y, dragging, vertex_grabbed, grabbed_index
    logic           cfg_we;
    logic [1:0]     cfg_addr;
    logic [TOL_BITS-1:0] cfg_data;

    quad_pick_drag_point_in_polygon_unit #(.COORD_BITS(CB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    // one quad snapshot as the block reports it
    typedef struct {
        logic [CB-1:0] cx[4];
        logic [CB-1:0] cy[4];
        logic          drag;
        logic          grab;
        logic [1:0]    idx;
    } quad_view_t;

    quad_view_t pending_views[$];

    // shadow of the block's state and registers
    longint quad_x[4], quad_y[4];
    bit     drag_on, corner_held;
    int     held_corner;
    longint last_px, last_py;
    int     win_w, win_h, grab_tol;

    int  errors = 0;
    int  stall_count = 0;
    bit  hold_req = 0;    // asks the receiver for one long hold-off
    bit  no_idle = 0;     // stretch with no idling on either side

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // ---------------- predictor ----------------
    function automatic longint sat_q(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // pixel to Q2.14, rounding half away from zero
    function automatic longint pix_to_q(longint pix, int size, bit flip);
        longint s, num, mag, q;
        s = (size < 2) ? 2 : size;
        num = 2 * pix - s;
        if (flip) num = -num;
        num = num * 16384;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + s) / (2 * s);
        return sat_q((num < 0) ? -q : q);
    endfunction

    // crossing-number test, exact cross-multiplication
    function automatic bit in_quad(longint nx, longint ny);
        int crossings;
        int j;
        longint dy, lhs, rhs;
        bit left;
        crossings = 0;
        for (int i = 0; i < 4; i++) begin
            j = (i + 1) % 4;
            if ((ny < quad_y[i]) != (ny < quad_y[j])) begin
                dy  = quad_y[j] - quad_y[i];
                lhs = (nx - quad_x[j]) * dy;
                rhs = (ny - quad_y[j]) * (quad_x[j] - quad_x[i]);
                left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                if (left) crossings++;
            end
        end
        return crossings[0];
    endfunction

    function automatic longint absl(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic quad_view_t apply_event(logic [1:0] cmd, int px, int py);
        longint nx, ny;
        quad_view_t v;
        nx = pix_to_q(px, win_w, 1'b0);
        ny = pix_to_q(py, win_h, 1'b1);
        case (cmd)
            CMD_PRESS: begin
                drag_on = 1;
                for (int i = 0; i < 4; i++) begin
                    if (absl(nx - quad_x[i]) < grab_tol && absl(ny - quad_y[i]) < grab_tol) begin
                        corner_held = 1;
                        held_corner = i;
                        break;
                    end
                end
                if (!corner_held && !in_quad(nx, ny)) drag_on = 0;
                last_px = nx;
                last_py = ny;
            end
            CMD_RELEASE: begin
                drag_on = 0;
                corner_held = 0;
            end
            CMD_MOTION: begin
                if (drag_on) begin
                    if (corner_held) begin
                        quad_x[held_corner] = nx;
                        quad_y[held_corner] = ny;
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            quad_x[i] = sat_q(quad_x[i] + (nx - last_px));
                            quad_y[i] = sat_q(quad_y[i] + (ny - last_py));
                        end
                        last_px = nx;
                        last_py = ny;
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++) begin
            v.cx[i] = quad_x[i][CB-1:0];
            v.cy[i] = quad_y[i][CB-1:0];
        end
        v.drag = drag_on;
        v.grab = corner_held;
        v.idx  = corner_held ? held_corner[1:0] : 2'd0;
        return v;
    endfunction

    // quad as it stands right after reset, with the given flags
    function automatic quad_view_t reset_quad(bit d, bit g, logic [1:0] ix);
        quad_view_t v;
        for (int i = 0; i < 4; i++) begin
            v.cx[i] = CB'(corner_rst_x(i));
            v.cy[i] = CB'(corner_rst_y(i));
        end
        v.drag = d;
        v.grab = g;
        v.idx  = ix;
        return v;
    endfunction

    // ---------------- sender ----------------
    task automatic send_event(logic [1:0] cmd, int px, int py, bit typed, quad_view_t typed_view);
        quad_view_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, 13'(py), 13'(px)};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_event(cmd, px, py);
        pending_views.push_back(typed ? typed_view : predicted);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // sender pause: let every expected result arrive, then the tail latency
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_views.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(int w, int h, int tol);
        cfg_we <= 1'b1; cfg_addr <= REG_WIDTH;  cfg_data <= TOL_BITS'(w & 12'hFFF);
        @(posedge aclk);
        cfg_addr <= REG_HEIGHT; cfg_data <= TOL_BITS'(h & 12'hFFF);
        @(posedge aclk);
        cfg_addr <= REG_TOL;    cfg_data <= TOL_BITS'(tol);
        @(posedge aclk);
        cfg_we <= 1'b0;
        win_w = w & 12'hFFF;
        win_h = h & 12'hFFF;
        grab_tol = tol;
    endtask

    // pixel position that lands near a normalized coordinate
    function automatic int q_to_px(longint q, int size, bit flip);
        longint s, p;
        s = (size < 2) ? 2 : size;
        p = flip ? ((16384 - q) * s) / 32768 : ((q + 16384) * s) / 32768;
        if (p > 4095) p = 4095;
        if (p < -4096) p = -4096;
        return int'(p);
    endfunction

    function automatic int rand_pix();
        return int'($urandom_range(8191)) - 4096;
    endfunction

    // one drag gesture: press on a corner, the middle or anywhere, moves, mostly a release
    task automatic gesture();
        int pick, tx, ty, c, moves;
        longint mx, my;
        quad_view_t none;
        pick = $urandom_range(99);
        c = $urandom_range(3);
        if (pick < 50) begin
            mx = quad_x[c] + $signed($urandom_range(2 * grab_tol + 64)) - grab_tol - 32;
            my = quad_y[c] + $signed($urandom_range(2 * grab_tol + 64)) - grab_tol - 32;
        end else if (pick < 85) begin
            mx = (quad_x[0] + quad_x[1] + quad_x[2] + quad_x[3]) / 4;
            my = (quad_y[0] + quad_y[1] + quad_y[2] + quad_y[3]) / 4;
        end else begin
            mx = $signed($urandom_range(65535)) - 32768;
            my = $signed($urandom_range(65535)) - 32768;
        end
        tx = q_to_px(mx, win_w, 1'b0);
        ty = q_to_px(my, win_h, 1'b1);
        send_event(CMD_PRESS, tx, ty, 0, none);
        moves = $urandom_range(1, 5);
        for (int k = 0; k < moves; k++) begin
            if ($urandom_range(9) == 0) begin
                tx = rand_pix();
                ty = rand_pix();
            end else begin
                tx = tx + $urandom_range(40) - 20;
                ty = ty + $urandom_range(40) - 20;
                if (tx > 4095) tx = 4095;
                if (tx < -4096) tx = -4096;
                if (ty > 4095) ty = 4095;
                if (ty < -4096) ty = -4096;
            end
            send_event(CMD_MOTION, tx, ty, 0, none);
        end
        // sometimes skip the release so a second press hits a held corner
        if ($urandom_range(4) != 0) send_event(CMD_RELEASE, tx, ty, 0, none);
    endtask

    task automatic random_events(int count);
        int sent;
        quad_view_t none;
        sent = pending_views.size();
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                gesture();
                sent += 5;
            end else begin
                send_event(2'($urandom_range(3)), rand_pix(), rand_pix(), 0, none);
                sent++;
            end
        end
    endtask

    // ---------------- directed table ----------------
    typedef struct {
        logic [1:0] cmd;
        int         px;
        int         py;
        bit         typed;    // expectation typed in below, else predicted
        bit         drag;
        bit         grab;
        logic [1:0] idx;
    } event_row_t;

    // default window 800 x 600, tolerance 819
    event_row_t directed_rows[] = '{
        '{CMD_MOTION,    400,   300, 1, 0, 0, 2'd0},   // motion with no drag
        '{CMD_RELEASE,     0,     0, 1, 0, 0, 2'd0},
        '{CMD_UNUSED,  -4096, -4096, 1, 0, 0, 2'd0},   // unused command
        '{CMD_PRESS,     200,   150, 1, 1, 1, 2'd0},   // lands exactly on corner 0
        '{CMD_PRESS,    4095,  4095, 0, 0, 0, 2'd0},   // press again, no match: stays held
        '{CMD_MOTION,      0,     0, 0, 0, 0, 2'd0},   // move corner 0
        '{CMD_PRESS,     600,   450, 0, 0, 0, 2'd0},   // re-press on corner 2, index replaced
        '{CMD_MOTION,   4095,  4095, 0, 0, 0, 2'd0},   // saturating coordinates
        '{CMD_RELEASE,  4095,  4095, 0, 0, 0, 2'd0},
        '{CMD_PRESS,     300,   300, 0, 0, 0, 2'd0},   // inside the quad
        '{CMD_MOTION,    310,   290, 0, 0, 0, 2'd0},   // translate
        '{CMD_MOTION,  -4096,  4095, 0, 0, 0, 2'd0},   // large translate, saturates
        '{CMD_MOTION,   4095, -4096, 0, 0, 0, 2'd0},
        '{CMD_RELEASE,     0,     0, 0, 0, 0, 2'd0},
        '{CMD_PRESS,    4095, -4096, 0, 0, 0, 2'd0},   // press where all corners saturated to: grabs corner 0
        '{CMD_MOTION,    100,   100, 0, 0, 0, 2'd0},   // moves held corner 0
        '{CMD_PRESS,      -1,    -1, 0, 0, 0, 2'd0},
        '{CMD_MOTION,    800,   600, 0, 0, 0, 2'd0},
        '{CMD_UNUSED,   4095,  4095, 0, 0, 0, 2'd0},
        '{CMD_RELEASE,  -4096, 4095, 0, 0, 0, 2'd0}
    };

    // ---------------- receiver ----------------
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // long hold-off: block fills and backs up the input
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        quad_view_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_views.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_views.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (m_tdata[32*i +: 16] !== want.cx[i]) begin
                        $display("%0t: corner%0d_x expected %0d got %0d", $time, i,
                                 $signed(want.cx[i]), $signed(m_tdata[32*i +: 16]));
                        errors++;
                    end
                    if (m_tdata[32*i+16 +: 16] !== want.cy[i]) begin
                        $display("%0t: corner%0d_y expected %0d got %0d", $time, i,
                                 $signed(want.cy[i]), $signed(m_tdata[32*i+16 +: 16]));
                        errors++;
                    end
                end
                if (m_tdata[128] !== want.drag) begin
                    $display("%0t: dragging expected %0b got %0b", $time, want.drag, m_tdata[128]);
                    errors++;
                end
                if (m_tdata[129] !== want.grab) begin
                    $display("%0t: vertex_grabbed expected %0b got %0b", $time,
                             want.grab, m_tdata[129]);
                    errors++;
                end
                if (m_tdata[131:130] !== want.idx) begin
                    $display("%0t: grabbed_index expected %0d got %0d", $time,
                             want.idx, m_tdata[131:130]);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles without any transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_PRESS;
        cfg_we   <= 1'b0;
        cfg_addr <= REG_WIDTH;
        cfg_data <= '0;
        for (int i = 0; i < 4; i++) begin
            quad_x[i] = longint'(corner_rst_x(i));
            quad_y[i] = longint'(corner_rst_y(i));
        end
        drag_on = 0; corner_held = 0; held_corner = 0;
        last_px = 0; last_py = 0;
        win_w = WIDTH_RST; win_h = HEIGHT_RST; grab_tol = TOL_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            send_event(directed_rows[r].cmd, directed_rows[r].px, directed_rows[r].py,
                       directed_rows[r].typed,
                       reset_quad(directed_rows[r].drag, directed_rows[r].grab,
                                  directed_rows[r].idx));
        random_events(ITEMS_PER_PHASE);

        // smallest window, zero tolerance (nothing grabs)
        drain();
        write_regs(2, 2, 0);
        random_events(ITEMS_PER_PHASE);

        // largest window and tolerance, with a long receiver hold-off
        drain();
        write_regs(4095, 4095, 16383);
        hold_req = 1;
        random_events(ITEMS_PER_PHASE);

        // sizes below two are taken as two
        drain();
        write_regs(0, 1, $urandom_range(16383));
        random_events(ITEMS_PER_PHASE / 2);

        // back to defaults, no idling on either side
        drain();
        write_regs(800, 600, 819);
        no_idle = 1;
        random_events(ITEMS_PER_PHASE / 2);
        no_idle = 0;

        drain();
        write_regs($urandom_range(2, 4095), $urandom_range(2, 4095), $urandom_range(16383));
        random_events(ITEMS_PER_PHASE);

        drain();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
